// File: hw/rtl/yuyv_to_rgb_converter_unit_assert.svh
// Assertion macros shared by the converter RTL.
`ifndef YUYV_TO_RGB_CONVERTER_UNIT_ASSERT_SVH
`define YUYV_TO_RGB_CONVERTER_UNIT_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define Y2R_ASSERT_SAME(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("same-cycle check failed");

// Check that a condition implies a consequence in the next cycle.
`define Y2R_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: hw/rtl/yuv2rgb_pkg.sv
// Types and constants for the YUYV to RGB converter.
package yuv2rgb_pkg;

    localparam int COEF_FRAC_BITS_DEFAULT = 14;
    localparam int COEF_FRAC_BITS_MIN     = 8;
    localparam int COEF_FRAC_BITS_MAX     = 18;

    // Coefficients in units of 1/10000.
    localparam longint COEF_RV_TENK = 14075;
    localparam longint COEF_GU_TENK = 3455;
    localparam longint COEF_GV_TENK = 7169;
    localparam longint COEF_BU_TENK = 17790;
    localparam longint COEF_SCALE   = 10000;
    localparam longint COEF_HALF    = 5000;

    localparam int BYTE_W = 8;

    typedef struct packed {
        logic [BYTE_W-1:0] luma_first;
        logic [BYTE_W-1:0] chroma_blue;
        logic [BYTE_W-1:0] luma_second;
        logic [BYTE_W-1:0] chroma_red;
        logic              frame_end;
    } yuyv_beat_t;

    typedef struct packed {
        logic [BYTE_W-1:0] red_first;
        logic [BYTE_W-1:0] green_first;
        logic [BYTE_W-1:0] blue_first;
        logic [BYTE_W-1:0] red_second;
        logic [BYTE_W-1:0] green_second;
        logic [BYTE_W-1:0] blue_second;
        logic              frame_end_out;
    } rgb_beat_t;

endpackage

// File: hw/rtl/yuv2rgb_stream_if.sv
// Valid/ready stream channel carrying one payload beat.
interface yuv2rgb_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

// File: hw/rtl/yuyv_to_rgb_converter_unit.sv
// Top level: YUYV 4:2:2 macropixel to two RGB888 pixels, four-stage pipeline.
//
// yuyv (sink) takes one macropixel per beat: two luma bytes, one shared U
// and V pair and an end-of-frame flag. rgb (source) returns one beat per
// macropixel with both RGB pixels and the copied flag, in input order.
// Channels use valid/ready; a beat moves when both are high.
//
// Pipeline: chroma offset removal, coefficient multiply, luma add,
// clamp to 0..255. Each beat moves through the stage registers s1, s2,
// s3 and s4 in order; rgb.valid is the stage-4 valid register.
// Throughput is one macropixel per cycle while rgb.ready stays high; each
// stage holds one beat and the multiply stage (four multipliers of about
// 16 by 9 bits) sets the cycle time.
//
// Reset (rst_n low) empties all stages; no output beat is shown until a
// new input is taken. When the receiver holds rgb.ready low, the output
// beat holds and the stages behind it fill; yuyv.ready drops once all
// four stages hold a beat, so nothing is dropped or repeated.
module yuyv_to_rgb_converter_unit
    import yuv2rgb_pkg::*;
#(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    yuv2rgb_stream_if.sink                        yuyv,
    yuv2rgb_stream_if.source                      rgb
);

`include "yuyv_to_rgb_converter_unit_assert.svh"

    localparam int SUM_W  = COEF_FRAC_BITS + 11;
    localparam int DIFF_W = BYTE_W + 1;

    localparam longint K_RV_L = ((COEF_RV_TENK << COEF_FRAC_BITS) + COEF_HALF) / COEF_SCALE;
    localparam longint K_GU_L = ((COEF_GU_TENK << COEF_FRAC_BITS) + COEF_HALF) / COEF_SCALE;
    localparam longint K_GV_L = ((COEF_GV_TENK << COEF_FRAC_BITS) + COEF_HALF) / COEF_SCALE;
    localparam longint K_BU_L = ((COEF_BU_TENK << COEF_FRAC_BITS) + COEF_HALF) / COEF_SCALE;

    localparam logic signed [SUM_W-1:0] K_RV = SUM_W'(K_RV_L);
    localparam logic signed [SUM_W-1:0] K_GU = SUM_W'(K_GU_L);
    localparam logic signed [SUM_W-1:0] K_GV = SUM_W'(K_GV_L);
    localparam logic signed [SUM_W-1:0] K_BU = SUM_W'(K_BU_L);

    localparam logic signed [DIFF_W-1:0] CHROMA_MID = DIFF_W'(128);

    // Truncate toward zero, then saturate; negatives clamp to 0.
    function automatic logic [BYTE_W-1:0] clamp_byte(input logic signed [SUM_W-1:0] fixed);
        logic [BYTE_W-1:0] result;
        if (fixed[SUM_W-1])
        begin
            result = '0;
        end
        else if (|fixed[SUM_W-2:COEF_FRAC_BITS+BYTE_W])
        begin
            result = '1;
        end
        else
        begin
            result = fixed[COEF_FRAC_BITS+BYTE_W-1:COEF_FRAC_BITS];
        end
        return result;
    endfunction

    // Stage enables: a stage loads when empty or when its beat moves on.
    logic en1;
    logic en2;
    logic en3;
    logic en4;

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic v4_reg;
    logic v1_next;
    logic v2_next;
    logic v3_next;
    logic v4_next;

    // Stage 1: chroma offsets removed.
    logic [BYTE_W-1:0]        s1_y0_reg;
    logic [BYTE_W-1:0]        s1_y1_reg;
    logic signed [DIFF_W-1:0] s1_du_reg;
    logic signed [DIFF_W-1:0] s1_dv_reg;
    logic                     s1_fe_reg;
    logic signed [DIFF_W-1:0] s1_du_next;
    logic signed [DIFF_W-1:0] s1_dv_next;

    // Stage 2: chroma products.
    logic [BYTE_W-1:0]        s2_y0_reg;
    logic [BYTE_W-1:0]        s2_y1_reg;
    logic signed [SUM_W-1:0]  s2_rv_reg;
    logic signed [SUM_W-1:0]  s2_gu_reg;
    logic signed [SUM_W-1:0]  s2_gv_reg;
    logic signed [SUM_W-1:0]  s2_bu_reg;
    logic                     s2_fe_reg;
    logic signed [SUM_W-1:0]  s2_rv_next;
    logic signed [SUM_W-1:0]  s2_gu_next;
    logic signed [SUM_W-1:0]  s2_gv_next;
    logic signed [SUM_W-1:0]  s2_bu_next;
    logic signed [SUM_W-1:0]  du_ext;
    logic signed [SUM_W-1:0]  dv_ext;

    // Stage 3: full fixed-point channel sums.
    logic signed [SUM_W-1:0]  s3_r0_reg;
    logic signed [SUM_W-1:0]  s3_g0_reg;
    logic signed [SUM_W-1:0]  s3_b0_reg;
    logic signed [SUM_W-1:0]  s3_r1_reg;
    logic signed [SUM_W-1:0]  s3_g1_reg;
    logic signed [SUM_W-1:0]  s3_b1_reg;
    logic                     s3_fe_reg;
    logic signed [SUM_W-1:0]  base0;
    logic signed [SUM_W-1:0]  base1;
    logic signed [SUM_W-1:0]  s3_r0_next;
    logic signed [SUM_W-1:0]  s3_g0_next;
    logic signed [SUM_W-1:0]  s3_b0_next;
    logic signed [SUM_W-1:0]  s3_r1_next;
    logic signed [SUM_W-1:0]  s3_g1_next;
    logic signed [SUM_W-1:0]  s3_b1_next;

    // Stage 4: output beat.
    rgb_beat_t                s4_beat_reg;
    rgb_beat_t                s4_beat_next;

    assign en4 = !v4_reg || rgb.ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign yuyv.ready = en1;
    assign rgb.valid  = v4_reg;
    assign rgb.data   = s4_beat_reg;

    assign v1_next = en1 ? yuyv.valid : v1_reg;
    assign v2_next = en2 ? v1_reg     : v2_reg;
    assign v3_next = en3 ? v2_reg     : v3_reg;
    assign v4_next = en4 ? v3_reg     : v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    always_comb
    begin
        s1_du_next = $signed({1'b0, yuyv.data.chroma_blue}) - CHROMA_MID;
        s1_dv_next = $signed({1'b0, yuyv.data.chroma_red}) - CHROMA_MID;
    end

    always_comb
    begin
        du_ext     = SUM_W'(s1_du_reg);
        dv_ext     = SUM_W'(s1_dv_reg);
        s2_rv_next = K_RV * dv_ext;
        s2_gu_next = K_GU * du_ext;
        s2_gv_next = K_GV * dv_ext;
        s2_bu_next = K_BU * du_ext;
    end

    always_comb
    begin
        base0      = $signed(SUM_W'(s2_y0_reg) << COEF_FRAC_BITS);
        base1      = $signed(SUM_W'(s2_y1_reg) << COEF_FRAC_BITS);
        s3_r0_next = base0 + s2_rv_reg;
        s3_g0_next = base0 - s2_gu_reg - s2_gv_reg;
        s3_b0_next = base0 + s2_bu_reg;
        s3_r1_next = base1 + s2_rv_reg;
        s3_g1_next = base1 - s2_gu_reg - s2_gv_reg;
        s3_b1_next = base1 + s2_bu_reg;
    end

    always_comb
    begin
        s4_beat_next.red_first     = clamp_byte(s3_r0_reg);
        s4_beat_next.green_first   = clamp_byte(s3_g0_reg);
        s4_beat_next.blue_first    = clamp_byte(s3_b0_reg);
        s4_beat_next.red_second    = clamp_byte(s3_r1_reg);
        s4_beat_next.green_second  = clamp_byte(s3_g1_reg);
        s4_beat_next.blue_second   = clamp_byte(s3_b1_reg);
        s4_beat_next.frame_end_out = s3_fe_reg;
    end

    // Payload registers: load only when the stage advances.
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_y0_reg <= yuyv.data.luma_first;
            s1_y1_reg <= yuyv.data.luma_second;
            s1_du_reg <= s1_du_next;
            s1_dv_reg <= s1_dv_next;
            s1_fe_reg <= yuyv.data.frame_end;
        end
        if (en2)
        begin
            s2_y0_reg <= s1_y0_reg;
            s2_y1_reg <= s1_y1_reg;
            s2_rv_reg <= s2_rv_next;
            s2_gu_reg <= s2_gu_next;
            s2_gv_reg <= s2_gv_next;
            s2_bu_reg <= s2_bu_next;
            s2_fe_reg <= s1_fe_reg;
        end
        if (en3)
        begin
            s3_r0_reg <= s3_r0_next;
            s3_g0_reg <= s3_g0_next;
            s3_b0_reg <= s3_b0_next;
            s3_r1_reg <= s3_r1_next;
            s3_g1_reg <= s3_g1_next;
            s3_b1_reg <= s3_b1_next;
            s3_fe_reg <= s2_fe_reg;
        end
        if (en4)
        begin
            s4_beat_reg <= s4_beat_next;
        end
    end

    `Y2R_ASSERT_SAME(a_full_before_stall, clk, rst_n, !yuyv.ready,
        v1_reg && v2_reg && v3_reg && v4_reg)
    `Y2R_ASSERT_NEXT(a_stage1_moves, clk, rst_n, v1_reg && en2, v2_reg)
    `Y2R_ASSERT_NEXT(a_negative_red_clamps, clk, rst_n, v3_reg && en4 && s3_r0_reg[SUM_W-1],
        rgb.valid && (rgb.data.red_first == '0))
    `Y2R_ASSERT_NEXT(a_flag_reaches_output, clk, rst_n, v3_reg && en4,
        rgb.data.frame_end_out == $past(s3_fe_reg))

endmodule
